### src/dmd_pkg.sv
// Package for the wrapped disk dilation block: field widths, defaults,
// request codes and the scan control struct. No dependencies.
`timescale 1ns / 1ps

package dmd_pkg;

   localparam int X_BITS       = 8;
   localparam int Y_BITS       = 8;
   localparam int ALT_BITS     = 24;
   localparam int OUT_BITS     = 23;
   localparam int RADIUS_BITS  = 6;
   localparam int OUT_MAX      = 8388607;

   localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 6'd30;

   localparam int DEF_LOG2_WIDTH  = 8;
   localparam int DEF_LOG2_HEIGHT = 8;
   localparam int DEF_SAMPLE_BITS = 24;
   localparam int DEF_MAX_RADIUS  = 63;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // one scan step as seen by the max unit
   typedef struct packed {
      logic vld;
      logic in_disk;
      logic last;
   } scan_ctl_type;

endpackage

### src/disk_max_dilation_wrap.sv
// Wrapped disk dilation: a write request stores one sample; a query request
// returns its result after a scan with r = min(radius, MAX_RADIUS), one map
// read per offset through the single RAM port.
// Writes sustain one per cycle; a query holds off requests until its result
// is taken. Reset clears control and sets radius to 30; the map is not cleared.
`timescale 1ns / 1ps

module disk_max_dilation_wrap #(
   parameter int LOG2_WIDTH  = dmd_pkg::DEF_LOG2_WIDTH,
   parameter int LOG2_HEIGHT = dmd_pkg::DEF_LOG2_HEIGHT,
   parameter int SAMPLE_BITS = dmd_pkg::DEF_SAMPLE_BITS,
   parameter int MAX_RADIUS  = dmd_pkg::DEF_MAX_RADIUS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_func,
   input  logic [dmd_pkg::X_BITS-1:0]          req_x,
   input  logic [dmd_pkg::Y_BITS-1:0]          req_y,
   input  logic signed [dmd_pkg::ALT_BITS-1:0] req_altitude,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [dmd_pkg::OUT_BITS-1:0]        rsp_dilated_altitude,
   input  logic                                csr_wr_en,
   input  logic [dmd_pkg::RADIUS_BITS-1:0]     csr_wr_data
);

   import dmd_pkg::*;

   localparam int ADDR_BITS = LOG2_WIDTH + LOG2_HEIGHT;
   localparam int RAD_BITS  = $clog2(MAX_RADIUS + 1);
   // storage range of one sample
   localparam logic signed [32:0] SMP_HI = 33'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [32:0] SMP_LO = 33'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

   logic [RADIUS_BITS-1:0]  radius_ff;
   logic                    query_busy_ff;
   logic                    rsp_valid_ff;
   logic [OUT_BITS-1:0]     rsp_data_ff;

   logic                    req_fire, wr_fire, start;
   logic [RAD_BITS-1:0]     rad_eff;
   logic signed [32:0]      alt_w;
   logic [SAMPLE_BITS-1:0]  wr_data;
   logic [ADDR_BITS-1:0]    wr_addr, scan_addr, ram_addr;
   logic [SAMPLE_BITS-1:0]  ram_rdata;
   scan_ctl_type            scan_ctl;
   logic                    max_done;
   logic [OUT_BITS-1:0]     max_result;

   // one request at a time: hold off while a query scans or its result waits
   assign req_ready = !query_busy_ff && !rsp_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign wr_fire   = req_fire && (req_func == FUNC_WRITE);
   assign start     = req_fire && (req_func == FUNC_QUERY);

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_dilated_altitude = rsp_data_ff;

   always_comb begin
      // radius saturates at MAX_RADIUS
      if (32'(radius_ff) > 32'(MAX_RADIUS)) begin
         rad_eff = RAD_BITS'(MAX_RADIUS);
      end else begin
         rad_eff = RAD_BITS'(radius_ff);
      end
      // write sample saturates to the storage width
      alt_w = 33'(req_altitude);
      if (alt_w > SMP_HI) begin
         wr_data = SAMPLE_BITS'(SMP_HI);
      end else if (alt_w < SMP_LO) begin
         wr_data = SAMPLE_BITS'(SMP_LO);
      end else begin
         wr_data = SAMPLE_BITS'(alt_w);
      end
      wr_addr  = {LOG2_HEIGHT'(req_y), LOG2_WIDTH'(req_x)};
      // port is free for writes whenever no scan runs
      ram_addr = wr_fire ? wr_addr : scan_addr;
   end

   dmd_map_ram #(
      .ADDR_BITS (ADDR_BITS),
      .DATA_BITS (SAMPLE_BITS)
   ) u_map (
      .clock (clock),
      .we    (wr_fire),
      .addr  (ram_addr),
      .wdata (wr_data),
      .rdata (ram_rdata)
   );

   dmd_scan #(
      .LOG2_WIDTH  (LOG2_WIDTH),
      .LOG2_HEIGHT (LOG2_HEIGHT),
      .RAD_BITS    (RAD_BITS)
   ) u_scan (
      .clock (clock),
      .reset (reset),
      .start (start),
      .cx    (LOG2_WIDTH'(req_x)),
      .cy    (LOG2_HEIGHT'(req_y)),
      .rad   (rad_eff),
      .addr  (scan_addr),
      .ctl   (scan_ctl)
   );

   // ctl is registered inside to line up with the registered RAM read
   dmd_max_unit #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_max (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .ctl    (scan_ctl),
      .rdata  (ram_rdata),
      .done   (max_done),
      .result (max_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff     <= RADIUS_RESET;
         query_busy_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            radius_ff <= csr_wr_data;
         end
         if (start) begin
            query_busy_ff <= 1'b1;
         end else if (max_done) begin
            query_busy_ff <= 1'b0;
         end
         if (max_done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (max_done) begin
         rsp_data_ff <= max_result;
      end
   end

`ifndef ASSERT_OFF
   a_scan_in_query: assert property (@(posedge clock) disable iff (reset)
      scan_ctl.vld |-> query_busy_ff)
      else $error("scan step outside a query");

   a_done_in_query: assert property (@(posedge clock) disable iff (reset)
      max_done |-> query_busy_ff && !rsp_valid_ff)
      else $error("result produced with no query pending");

   a_busy_rsp_excl: assert property (@(posedge clock) disable iff (reset)
      !(query_busy_ff && rsp_valid_ff))
      else $error("result shown while the scan still runs");
`endif

endmodule

### src/dmd_map_ram.sv
// Height map storage: single port, synchronous write, registered read.
// No dependencies.
`timescale 1ns / 1ps

module dmd_map_ram #(
   parameter int ADDR_BITS = 16,
   parameter int DATA_BITS = 24
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] addr,
   input  logic [DATA_BITS-1:0] wdata,
   output logic [DATA_BITS-1:0] rdata
);

   logic [DATA_BITS-1:0] mem_ff [2**ADDR_BITS];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end

endmodule

### src/dmd_scan.sv
// Offset sequencer: walks dy, dx over the square of side 2r+1, keeps dx^2 and
// dy^2 by incremental update, flags offsets inside the disk. Uses dmd_pkg.
`timescale 1ns / 1ps

module dmd_scan #(
   parameter int LOG2_WIDTH  = 8,
   parameter int LOG2_HEIGHT = 8,
   parameter int RAD_BITS    = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [LOG2_WIDTH-1:0]             cx,
   input  logic [LOG2_HEIGHT-1:0]            cy,
   input  logic [RAD_BITS-1:0]               rad,
   output logic [LOG2_WIDTH+LOG2_HEIGHT-1:0] addr,
   output dmd_pkg::scan_ctl_type             ctl
);

   import dmd_pkg::*;

   localparam int OFS_BITS = RAD_BITS + 1;
   localparam int SQ_BITS  = 2 * RAD_BITS + 1;
   localparam int AXW = ((LOG2_WIDTH > OFS_BITS) ? LOG2_WIDTH : OFS_BITS) + 1;
   localparam int AYW = ((LOG2_HEIGHT > OFS_BITS) ? LOG2_HEIGHT : OFS_BITS) + 1;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type                   state_ff;
   logic signed [OFS_BITS-1:0]  dx_ff, dy_ff, r_ff;
   logic [SQ_BITS-1:0]          dxsq_ff, dysq_ff, rsq_ff;
   logic [LOG2_WIDTH-1:0]       cx_ff;
   logic [LOG2_HEIGHT-1:0]      cy_ff;

   logic [SQ_BITS-1:0]          rad_w, rad_sq;
   logic signed [OFS_BITS-1:0]  rad_s;
   logic [SQ_BITS:0]            sum_sq;
   logic signed [SQ_BITS+1:0]   dxsq_in, dysq_in;
   logic [AXW-1:0]              sx_sum;
   logic [AYW-1:0]              sy_sum;
   logic                        row_end, last;

   always_comb begin
      rad_w   = SQ_BITS'(rad);
      rad_sq  = rad_w * rad_w;
      rad_s   = signed'({1'b0, rad});
      sum_sq  = (SQ_BITS+1)'(dxsq_ff) + (SQ_BITS+1)'(dysq_ff);
      // (d+1)^2 = d^2 + 2d + 1
      dxsq_in = signed'({2'b00, dxsq_ff}) + ((SQ_BITS+2)'(dx_ff) <<< 1)
                + (SQ_BITS+2)'(1);
      dysq_in = signed'({2'b00, dysq_ff}) + ((SQ_BITS+2)'(dy_ff) <<< 1)
                + (SQ_BITS+2)'(1);
      row_end = (dx_ff == r_ff);
      last    = row_end && (dy_ff == r_ff);
      // coordinates wrap: keep the low bits of the sum
      sx_sum  = AXW'(cx_ff) + AXW'(dx_ff);
      sy_sum  = AYW'(cy_ff) + AYW'(dy_ff);
      addr    = {sy_sum[LOG2_HEIGHT-1:0], sx_sum[LOG2_WIDTH-1:0]};
      ctl.vld     = (state_ff == ST_RUN);
      ctl.in_disk = (sum_sq <= (SQ_BITS+1)'(rsq_ff));
      ctl.last    = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_RUN;
                  cx_ff    <= cx;
                  cy_ff    <= cy;
                  r_ff     <= rad_s;
                  dx_ff    <= -rad_s;
                  dy_ff    <= -rad_s;
                  rsq_ff   <= rad_sq;
                  dxsq_ff  <= rad_sq;
                  dysq_ff  <= rad_sq;
               end
            end
            ST_RUN: begin
               if (last) begin
                  state_ff <= ST_IDLE;
               end else if (row_end) begin
                  dx_ff   <= -r_ff;
                  dxsq_ff <= rsq_ff;
                  dy_ff   <= dy_ff + OFS_BITS'(1);
                  dysq_ff <= SQ_BITS'(dysq_in);
               end else begin
                  dx_ff   <= dx_ff + OFS_BITS'(1);
                  dxsq_ff <= SQ_BITS'(dxsq_in);
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

### src/dmd_max_unit.sv
// Running maximum over in-disk map reads, floor at zero, clamp to the output
// range. Uses dmd_pkg.
`timescale 1ns / 1ps

module dmd_max_unit #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  dmd_pkg::scan_ctl_type         ctl,
   input  logic [SAMPLE_BITS-1:0]        rdata,
   output logic                          done,
   output logic [dmd_pkg::OUT_BITS-1:0]  result
);

   import dmd_pkg::*;

   scan_ctl_type                  ctl_d_ff;
   logic signed [SAMPLE_BITS-1:0] best_ff;
   logic signed [SAMPLE_BITS-1:0] sample, best_in;
   logic signed [32:0]            best_w;

   always_comb begin
      sample  = signed'(rdata);
      best_in = best_ff;
      if (ctl_d_ff.vld && ctl_d_ff.in_disk && (sample > best_ff)) begin
         best_in = sample;
      end
      done   = ctl_d_ff.vld && ctl_d_ff.last;
      best_w = 33'(best_in);
      if (best_w > 33'(OUT_MAX)) begin
         result = OUT_BITS'(OUT_MAX);
      end else begin
         result = OUT_BITS'(best_w);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_d_ff <= '0;
      end else begin
         ctl_d_ff <= ctl;
      end
      if (start) begin
         best_ff <= '0;
      end else begin
         best_ff <= best_in;
      end
   end

endmodule
